/* rtl/lpfr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package lpfr_pkg;

  localparam int unsigned ByteW     = 8;
  localparam int unsigned PosW      = 9;
  localparam int unsigned OutDataW  = 48;

  localparam logic [ByteW-1:0] SumInit       = 8'hFF;
  localparam logic [ByteW-1:0] MaxPayloadRst = 8'd252;
  localparam logic [ByteW-1:0] HeaderLen     = 8'd3;
  localparam logic [PosW-1:0]  FirstPayload  = 9'd4;
  localparam logic [PosW-1:0]  FrameOverhead = 9'd4;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_SHORT     = 2'd1,
    STATUS_BAD_SUM   = 2'd2,
    STATUS_TOO_LONG  = 2'd3
  } lpfr_status_t;

  // One result beat as it leaves the parser.
  typedef struct packed {
    logic [ByteW-1:0] payload_length;
    logic [ByteW-1:0] frame_seq;
    logic [ByteW-1:0] frame_ref;
    logic [ByteW-1:0] frame_type;
    lpfr_status_t     status;
    logic [ByteW-1:0] data_byte;
    logic             data_valid;
    logic             frame_end;
  } lpfr_result_t;

endpackage

`default_nettype wire

/* rtl/lpfr_parser.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpfr_parser (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       accept,
  input  wire logic [lpfr_pkg::ByteW-1:0] rx_byte,
  input  wire logic [lpfr_pkg::ByteW-1:0] max_payload_len,
  output lpfr_pkg::lpfr_result_t          result
);

  logic [lpfr_pkg::PosW-1:0]  pos_r, pos_nxt;
  logic [lpfr_pkg::PosW-1:0]  total_r, total_nxt;
  logic [lpfr_pkg::ByteW-1:0] len_r, len_nxt;
  logic [lpfr_pkg::ByteW-1:0] even_r, even_nxt;
  logic [lpfr_pkg::ByteW-1:0] odd_r, odd_nxt;
  logic [lpfr_pkg::ByteW-1:0] type_r, type_nxt;
  logic [lpfr_pkg::ByteW-1:0] ref_r, ref_nxt;
  logic [lpfr_pkg::ByteW-1:0] seq_r, seq_nxt;

  logic [lpfr_pkg::PosW-1:0]  total_cur;
  logic [lpfr_pkg::ByteW-1:0] len_cur;
  logic [lpfr_pkg::PosW:0]    pos_inc;
  logic                       is_last;
  logic                       is_payload;
  logic                       is_short;
  logic [lpfr_pkg::ByteW-1:0] plen;
  lpfr_pkg::lpfr_status_t     status;

  always_comb begin
    // The length byte takes effect on the same beat it arrives.
    if (pos_r == '0) begin
      len_cur   = rx_byte;
      total_cur = {1'b0, rx_byte} + lpfr_pkg::FrameOverhead
                  - {{(lpfr_pkg::PosW-1){1'b0}}, rx_byte[0]};
    end else begin
      len_cur   = len_r;
      total_cur = total_r;
    end

    type_nxt = (pos_r == 9'd1) ? rx_byte : type_r;
    ref_nxt  = (pos_r == 9'd2) ? rx_byte : ref_r;
    seq_nxt  = (pos_r == 9'd3) ? rx_byte : seq_r;

    even_nxt = pos_r[0] ? even_r : (even_r ^ rx_byte);
    odd_nxt  = pos_r[0] ? (odd_r ^ rx_byte) : odd_r;

    is_payload = (pos_r >= lpfr_pkg::FirstPayload) && (pos_r <= {1'b0, len_r});
    pos_inc    = {1'b0, pos_r} + 10'd1;
    is_last    = pos_inc >= {1'b0, total_cur};

    is_short = len_cur < lpfr_pkg::HeaderLen;
    plen     = is_short ? '0 : (len_cur - lpfr_pkg::HeaderLen);
    if (is_short) begin
      status = lpfr_pkg::STATUS_SHORT;
    end else if ((even_nxt != '0) || (odd_nxt != '0)) begin
      status = lpfr_pkg::STATUS_BAD_SUM;
    end else if (plen > max_payload_len) begin
      status = lpfr_pkg::STATUS_TOO_LONG;
    end else begin
      status = lpfr_pkg::STATUS_OK;
    end

    result.data_valid     = is_payload;
    result.data_byte      = is_payload ? rx_byte : '0;
    result.frame_end      = is_last;
    result.status         = is_last ? status : lpfr_pkg::STATUS_OK;
    result.frame_type     = is_last ? type_nxt : '0;
    result.frame_ref      = is_last ? ref_nxt : '0;
    result.frame_seq      = is_last ? seq_nxt : '0;
    result.payload_length = is_last ? plen : '0;

    // At the end of a frame the tracker rearms for the next length byte.
    if (is_last) begin
      pos_nxt   = '0;
      total_nxt = '0;
      len_nxt   = '0;
      even_nxt  = lpfr_pkg::SumInit;
      odd_nxt   = lpfr_pkg::SumInit;
    end else begin
      pos_nxt   = pos_inc[lpfr_pkg::PosW-1:0];
      total_nxt = total_cur;
      len_nxt   = len_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      total_r <= '0;
      len_r   <= '0;
      even_r  <= lpfr_pkg::SumInit;
      odd_r   <= lpfr_pkg::SumInit;
      type_r  <= '0;
      ref_r   <= '0;
      seq_r   <= '0;
    end else if (accept) begin
      pos_r   <= pos_nxt;
      total_r <= total_nxt;
      len_r   <= len_nxt;
      even_r  <= even_nxt;
      odd_r   <= odd_nxt;
      type_r  <= type_nxt;
      ref_r   <= ref_nxt;
      seq_r   <= seq_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/lpfr_out_reg.sv */
`timescale 1ns / 1ps
`default_nettype none

module lpfr_out_reg (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   load_valid,
  output logic                        load_ready,
  input  wire lpfr_pkg::lpfr_result_t load_data,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output lpfr_pkg::lpfr_result_t      out_data
);

  logic                   valid_r;
  lpfr_pkg::lpfr_result_t data_r;

  // The register refills in the same cycle its beat is taken.
  assign load_ready = !valid_r || out_ready;
  assign out_valid  = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_ready) begin
      valid_r <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ready && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/length_prefixed_frame_receiver.sv */
`timescale 1ns / 1ps
`default_nettype none

// An accepted input beat's result beat appears on the out_ side in the next cycle.
// Throughput: one byte per cycle while out_tready is high, set by the frame tracker
// update feeding the output register, which refills in the cycle its beat is taken.
// Reset (rst_n low, synchronous): the tracker waits for a length byte, both
// checksum lanes return to 0xFF, held header bytes clear and max_payload_len is 252.

module length_prefixed_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,

  // Received byte stream.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte

  // One result beat per received byte.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [lpfr_pkg::OutDataW-1:0] out_tdata,
                                       // [7:0] data_byte, [9:8] status,
                                       // [17:10] frame_type, [25:18] frame_ref,
                                       // [33:26] frame_seq, [41:34] payload_length,
                                       // [47:42] zero
  output logic             out_tlast,  // frame_end
  output logic             out_tuser,  // [0] data_valid

  // Configuration write of max_payload_len.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);

  logic [lpfr_pkg::ByteW-1:0] max_len_r;
  logic                       in_accept;
  lpfr_pkg::lpfr_result_t     parse_res;
  lpfr_pkg::lpfr_result_t     held_res;

  // The limit register takes a write on any cycle; the user must send writes only
  // while idle, which the block does not enforce, so no frame sees it change halfway.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= lpfr_pkg::MaxPayloadRst;
    end else if (cfg_valid) begin
      max_len_r <= cfg_data;
    end
  end

  assign in_accept = in_tvalid && in_tready;

  // The tracker builds each result straight from the incoming byte and its
  // own state, and advances that state only when the beat is accepted.
  lpfr_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .rx_byte         (in_tdata),
    .max_payload_len (max_len_r),
    .result          (parse_res)
  );

  // The output register separates the two handshakes, so a waiting result
  // does not hold up the next byte unless the consumer is stalled.
  lpfr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (in_tvalid),
    .load_ready (in_tready),
    .load_data  (parse_res),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (held_res)
  );

  assign out_tdata = {6'd0,
                      held_res.payload_length,
                      held_res.frame_seq,
                      held_res.frame_ref,
                      held_res.frame_type,
                      held_res.status,
                      held_res.data_byte};
  assign out_tlast = held_res.frame_end;
  assign out_tuser = held_res.data_valid;

endmodule

`default_nettype wire
